// ===== rtl/btmx_pkg.sv =====
// shared constants, codes and types of the binary trie minimum-xor block
`default_nettype none
package btmx_pkg;

    localparam int KEY_W      = 31;
    localparam int KEY_BITS   = 31;
    localparam int NODE_COUNT = 4096;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LINK_W     = 2 * NODE_W;
    localparam int BIT_W      = $clog2(KEY_BITS);
    localparam int COUNT_W    = 13;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // opcodes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LINK,
        ST_ALLOC,
        ST_RESP
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic link;
        logic alloc;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic go_walk;
        logic diverge;
        logic fits;
        logic walk_done;
        logic last_bit;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/btmx_if.sv =====
// valid/ready channel interfaces for request and result beats
`default_nettype none
interface btmx_in_if;
    logic                         valid;
    logic                         ready;
    logic [btmx_pkg::OP_W-1:0]    opcode;
    logic [btmx_pkg::KEY_W-1:0]   key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface btmx_out_if;
    logic                           valid;
    logic                           ready;
    logic [btmx_pkg::KEY_W-1:0]     min_xor;
    logic [btmx_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output min_xor, output status, input ready);
    modport sink   (input valid, input min_xor, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/btmx_ctrl.sv =====
// controller state machine sequencing walk, link and node allocation
`default_nettype none
module btmx_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_free,
    input  wire btmx_pkg::t_stat i_stat,
    output btmx_pkg::t_cmd       o_cmd,
    output logic                 o_in_ready
);

    btmx_pkg::t_state r_state;
    btmx_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btmx_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            btmx_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.go_walk ? btmx_pkg::ST_WALK : btmx_pkg::ST_RESP;
                end
            end
            btmx_pkg::ST_WALK: begin
                if (i_stat.diverge) begin
                    n_state = i_stat.fits ? btmx_pkg::ST_LINK : btmx_pkg::ST_RESP;
                end else if (i_stat.walk_done) begin
                    n_state = btmx_pkg::ST_RESP;
                end
            end
            btmx_pkg::ST_LINK: begin
                n_state = btmx_pkg::ST_ALLOC;
            end
            btmx_pkg::ST_ALLOC: begin
                if (i_stat.last_bit) begin
                    n_state = btmx_pkg::ST_RESP;
                end
            end
            btmx_pkg::ST_RESP: begin
                if (i_out_free) begin
                    n_state = btmx_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = btmx_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            btmx_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            btmx_pkg::ST_WALK: begin
                o_cmd.walk = 1'b1;
            end
            btmx_pkg::ST_LINK: begin
                o_cmd.link = 1'b1;
            end
            btmx_pkg::ST_ALLOC: begin
                o_cmd.alloc = 1'b1;
            end
            btmx_pkg::ST_RESP: begin
                o_cmd.emit = i_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/btmx_datapath.sv =====
// node memory, walk registers, allocator and counters of the trie
`default_nettype none
module btmx_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire btmx_pkg::t_cmd                 i_cmd,
    input  wire logic [btmx_pkg::OP_W-1:0]      i_op,
    input  wire logic [btmx_pkg::KEY_W-1:0]     i_key,
    output btmx_pkg::t_stat                     o_stat,
    output logic [btmx_pkg::KEY_W-1:0]          o_min_xor,
    output logic [btmx_pkg::STATUS_W-1:0]       o_status
);

    localparam int NW = btmx_pkg::NODE_W;
    localparam int LW = btmx_pkg::LINK_W;
    localparam int BW = btmx_pkg::BIT_W;

    // node memory, child 1 in the upper half and child 0 in the lower half
    logic [LW-1:0] mem [btmx_pkg::NODE_COUNT];

    logic [btmx_pkg::OP_W-1:0]     r_op;
    logic [btmx_pkg::KEY_W-1:0]    r_key;
    logic [NW-1:0]                 r_node;
    logic [BW-1:0]                 r_bit;
    logic [btmx_pkg::KEY_W-1:0]    r_acc;
    logic [LW-1:0]                 r_dentry;
    logic [btmx_pkg::STATUS_W-1:0] r_status;
    logic [LW-1:0]                 r_rdata;
    logic [LW-1:0]                 r_root;
    logic [NW-1:0]                 r_last;
    logic [btmx_pkg::COUNT_W-1:0]  r_count;

    logic [LW-1:0] entry;
    logic          kbit;
    logic          kbit_next;
    logic [NW-1:0] link_b;
    logic [NW-1:0] link_o;
    logic          is_ins;
    logic          take_b;
    logic          take_o;
    logic          stop;
    logic          diverge;
    logic          last_bit;
    logic          walk_done;
    logic          fits;
    logic [NW:0]   need_sum;
    logic [NW-1:0] next_node;
    logic [NW-1:0] new_node;
    logic [NW-1:0] new_child;
    logic [LW-1:0] link_entry;
    logic [LW-1:0] alloc_entry;
    logic          mem_we;
    logic [NW-1:0] mem_wa;
    logic [LW-1:0] mem_wd;
    logic          count_inc;

    // current node entry: root lives in flops, the rest in memory
    assign entry  = (r_node == '0) ? r_root : r_rdata;
    assign kbit   = r_key[r_bit];
    assign link_b = kbit ? entry[LW-1:NW] : entry[NW-1:0];
    assign link_o = kbit ? entry[NW-1:0] : entry[LW-1:NW];
    assign is_ins = (r_op == btmx_pkg::OP_INSERT);

    // walk decisions
    assign take_b    = (link_b != '0);
    assign take_o    = !is_ins && !take_b && (link_o != '0);
    assign stop      = !take_b && !take_o;
    assign diverge   = is_ins && !take_b;
    assign last_bit  = (r_bit == '0);
    assign walk_done = !diverge && (last_bit || stop);
    assign next_node = take_b ? link_b : link_o;

    // room check: nodes still needed are the remaining key bits from here down
    assign need_sum = (NW+1)'(r_last) + (NW+1)'(r_bit) + (NW+1)'(1);
    assign fits     = (need_sum <= (NW+1)'(btmx_pkg::NODE_COUNT - 1));

    // allocation entries
    assign new_node  = r_last + NW'(1);
    assign new_child = new_node + NW'(1);
    assign kbit_next = last_bit ? 1'b0 : r_key[r_bit - BW'(1)];

    always_comb begin
        link_entry = r_dentry;
        if (kbit) begin
            link_entry[LW-1:NW] = new_node;
        end else begin
            link_entry[NW-1:0] = new_node;
        end
    end

    always_comb begin
        alloc_entry = '0;
        if (!last_bit) begin
            if (kbit_next) begin
                alloc_entry[LW-1:NW] = new_child;
            end else begin
                alloc_entry[NW-1:0] = new_child;
            end
        end
    end

    // memory write port
    assign mem_we = (i_cmd.link && (r_node != '0)) || i_cmd.alloc;
    assign mem_wa = i_cmd.alloc ? new_node : r_node;
    assign mem_wd = i_cmd.alloc ? alloc_entry : link_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[next_node];
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_key  <= i_key;
            r_node <= '0;
            r_bit  <= BW'(btmx_pkg::KEY_BITS - 1);
            r_acc  <= '0;
            if ((i_op == btmx_pkg::OP_QUERY) && (r_count == '0)) begin
                r_status <= btmx_pkg::STAT_EMPTY;
            end else begin
                r_status <= btmx_pkg::STAT_OK;
            end
        end else if (i_cmd.walk) begin
            if (take_o) begin
                r_acc[r_bit] <= 1'b1;
            end
            if (diverge) begin
                r_dentry <= entry;
                if (!fits) begin
                    r_status <= btmx_pkg::STAT_FULL;
                end
            end else if (!walk_done) begin
                r_node <= next_node;
                r_bit  <= r_bit - BW'(1);
            end
        end else if (i_cmd.alloc && !last_bit) begin
            r_bit <= r_bit - BW'(1);
        end
    end

    // trie bookkeeping
    assign count_inc = (i_cmd.walk && walk_done && is_ins) || (i_cmd.alloc && last_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root  <= '0;
            r_last  <= '0;
            r_count <= '0;
        end else if (i_cmd.load && (i_op == btmx_pkg::OP_CLEAR)) begin
            r_root  <= '0;
            r_last  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.link && (r_node == '0)) begin
                r_root <= link_entry;
            end
            if (i_cmd.alloc) begin
                r_last <= new_node;
            end
            if (count_inc && (r_count != btmx_pkg::COUNT_MAX)) begin
                r_count <= r_count + btmx_pkg::COUNT_W'(1);
            end
        end
    end

    // status to controller
    always_comb begin
        o_stat.go_walk   = (i_op == btmx_pkg::OP_INSERT) ||
                           ((i_op == btmx_pkg::OP_QUERY) && (r_count != '0));
        o_stat.diverge   = diverge;
        o_stat.fits      = fits;
        o_stat.walk_done = walk_done;
        o_stat.last_bit  = last_bit;
    end

    assign o_min_xor = r_acc;
    assign o_status  = r_status;

endmodule
`default_nettype wire

// ===== rtl/binary_trie_min_xor_top.sv =====
// top level: minimum-xor binary trie with controller, datapath and result register
// sequence: clear and unused opcode go from the accepted beat straight to the result state;
//   query and duplicate insert walk the trie, one node memory read per key bit walked;
//   insert that allocates adds a link write and one node memory write per new node
// flow: one beat at a time, next beat taken once the result is in the output register
// reset: synchronous active low, empties the trie at once; no memory clearing pass
`default_nettype none
module binary_trie_min_xor_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    btmx_in_if.sink    i_req,
    btmx_out_if.source o_rsp
);

    btmx_pkg::t_cmd  cmd;
    btmx_pkg::t_stat stat;
    logic            out_free;
    logic            in_ready;
    logic [btmx_pkg::KEY_W-1:0]    dp_min_xor;
    logic [btmx_pkg::STATUS_W-1:0] dp_status;

    logic                          r_out_valid;
    logic [btmx_pkg::KEY_W-1:0]    r_out_xor;
    logic [btmx_pkg::STATUS_W-1:0] r_out_status;

    assign out_free = !r_out_valid || o_rsp.ready;

    btmx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    btmx_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_op      (i_req.opcode),
        .i_key     (i_req.key),
        .o_stat    (stat),
        .o_min_xor (dp_min_xor),
        .o_status  (dp_status)
    );

    assign i_req.ready = in_ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out_xor    <= dp_min_xor;
            r_out_status <= dp_status;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.min_xor = r_out_xor;
    assign o_rsp.status  = r_out_status;

`ifndef SYNTH
    // allocation never runs past the last node
    a_alloc_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.link || cmd.alloc) |-> stat.fits)
        else $error("node allocation past the end of the node memory");

    // one beat in flight: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("input taken while a beat is in flight");

    // a result that is not ok carries a zero xor
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != btmx_pkg::STAT_OK)) |-> (o_rsp.min_xor == '0))
        else $error("error result with nonzero xor");
`endif

endmodule
`default_nettype wire

// ===== tb/binary_trie_min_xor_top_tb.sv =====
// self-checking testbench of the binary trie minimum-xor block: directed and random beats
module binary_trie_min_xor_top_tb;

    localparam int ITEM_COUNT      = 1750;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 400;

    typedef struct packed {
        btmx_pkg::t_op              op;
        logic [btmx_pkg::KEY_W-1:0] key;
    } t_req_beat;

    typedef struct packed {
        logic [btmx_pkg::KEY_W-1:0]    min_xor;
        logic [btmx_pkg::STATUS_W-1:0] status;
    } t_rsp_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    btmx_in_if  req_if ();
    btmx_out_if rsp_if ();

    binary_trie_min_xor_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // shadow copy of the trie
    logic [btmx_pkg::NODE_W-1:0]  shadow_links [btmx_pkg::NODE_COUNT][2];
    int                           shadow_last;
    logic [btmx_pkg::COUNT_W-1:0] shadow_keys;

    t_req_beat                  beats_to_send [$];
    t_rsp_beat                  answers_due [$];
    logic [btmx_pkg::KEY_W-1:0] key_pool [$];

    t_req_beat offered;
    t_rsp_beat want;
    int n_sent       = 0;
    int n_results    = 0;
    int n_errors     = 0;
    int n_full       = 0;
    int n_empty      = 0;
    int n_answered   = 0;
    int peak_node    = 0;
    int peak_keys    = 0;
    int total_beats  = 0;
    int send_gap     = 0;
    int send_quiet   = 0;
    int recv_hold    = 0;
    int recv_quiet   = 0;
    int quiet_cycles = 0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [btmx_pkg::STATUS_W-1:0] shadow_insert(
        input logic [btmx_pkg::KEY_W-1:0] key);
        int node;
        int need;
        int nx;
        node = 0;
        need = 0;
        // count the nodes still missing on the path
        for (int i = btmx_pkg::KEY_BITS - 1; i >= 0 && need == 0; i--) begin
            nx = shadow_links[node][key[i]];
            if (nx == 0) need = i + 1;
            else node = nx;
        end
        if (shadow_last + need > btmx_pkg::NODE_COUNT - 1) return btmx_pkg::STAT_FULL;
        // allocate along the path, each new node starts with no children
        node = 0;
        for (int i = btmx_pkg::KEY_BITS - 1; i >= 0; i--) begin
            if (shadow_links[node][key[i]] == 0) begin
                shadow_last++;
                shadow_links[shadow_last][0] = '0;
                shadow_links[shadow_last][1] = '0;
                shadow_links[node][key[i]] = btmx_pkg::NODE_W'(shadow_last);
            end
            node = shadow_links[node][key[i]];
        end
        if (shadow_keys != btmx_pkg::COUNT_MAX) shadow_keys++;
        return btmx_pkg::STAT_OK;
    endfunction

    function automatic logic [btmx_pkg::KEY_W-1:0] shadow_query(
        input logic [btmx_pkg::KEY_W-1:0] key);
        int                         node;
        bit                         stuck;
        logic [btmx_pkg::KEY_W-1:0] acc;
        node  = 0;
        stuck = 1'b0;
        acc   = '0;
        // prefer the matching branch, otherwise pay for that bit
        for (int i = btmx_pkg::KEY_BITS - 1; i >= 0 && !stuck; i--) begin
            if (shadow_links[node][key[i]] != 0) begin
                node = shadow_links[node][key[i]];
            end else if (shadow_links[node][!key[i]] != 0) begin
                node   = shadow_links[node][!key[i]];
                acc[i] = 1'b1;
            end else begin
                stuck = 1'b1;
            end
        end
        return acc;
    endfunction

    function automatic t_rsp_beat shadow_step(input t_req_beat beat);
        t_rsp_beat r;
        r.min_xor = '0;
        r.status  = btmx_pkg::STAT_OK;
        case (beat.op)
            btmx_pkg::OP_CLEAR: begin
                shadow_links[0][0] = '0;
                shadow_links[0][1] = '0;
                shadow_last        = 0;
                shadow_keys        = '0;
            end
            btmx_pkg::OP_INSERT: begin
                r.status = shadow_insert(beat.key);
                if (r.status == btmx_pkg::STAT_FULL) n_full++;
            end
            btmx_pkg::OP_QUERY: begin
                if (shadow_keys == 0) begin
                    r.status = btmx_pkg::STAT_EMPTY;
                    n_empty++;
                end else begin
                    r.min_xor = shadow_query(beat.key);
                    n_answered++;
                end
            end
            default: ;
        endcase
        if (shadow_last > peak_node) peak_node = shadow_last;
        if (int'(shadow_keys) > peak_keys) peak_keys = shadow_keys;
        return r;
    endfunction

    function automatic logic [btmx_pkg::KEY_W-1:0] fresh_key();
        case ($urandom_range(0, 9))
            0: return btmx_pkg::KEY_W'($urandom_range(0, 63));
            1: return {btmx_pkg::KEY_W{1'b1}} - btmx_pkg::KEY_W'($urandom_range(0, 63));
            default: return btmx_pkg::KEY_W'($urandom);
        endcase
    endfunction

    // key that shares a long prefix with a stored one
    function automatic logic [btmx_pkg::KEY_W-1:0] near_key(
        input logic [btmx_pkg::KEY_W-1:0] base);
        int width;
        width = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
                                             : $urandom_range(1, btmx_pkg::KEY_W);
        return base ^ (btmx_pkg::KEY_W'($urandom) &
                       btmx_pkg::KEY_W'((64'd1 << width) - 1));
    endfunction

    function automatic logic [btmx_pkg::KEY_W-1:0] pick_key(input int fresh_pct);
        int r;
        r = $urandom_range(0, 99);
        if (key_pool.size() == 0 || r < fresh_pct) return fresh_key();
        if (r < fresh_pct + (100 - fresh_pct) / 2)
            return near_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    task automatic push_beat(input btmx_pkg::t_op op, input logic [btmx_pkg::KEY_W-1:0] key);
        t_req_beat b;
        b.op  = op;
        b.key = key;
        beats_to_send.insert(beats_to_send.size(), b);
    endtask

    // driver: offers queued beats with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                answers_due.insert(answers_due.size(), shadow_step(offered));
                n_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (beats_to_send.size() > 0) begin
                    offered = beats_to_send.pop_front();
                    req_if.valid  <= 1'b1;
                    req_if.opcode <= offered.op;
                    req_if.key    <= offered.key;
                    if (send_quiet > 0) begin
                        send_quiet--;
                        send_gap = 0;
                    end else begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 99) < 3) send_quiet = $urandom_range(20, 80);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_results++;
                if (answers_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result min_xor %h status %0d", $time,
                             rsp_if.min_xor, rsp_if.status);
                end else begin
                    want = answers_due.pop_front();
                    if (rsp_if.min_xor !== want.min_xor) begin
                        n_errors++;
                        $display("%0t: min_xor expected %h got %h", $time,
                                 want.min_xor, rsp_if.min_xor);
                    end
                    if (rsp_if.status !== want.status) begin
                        n_errors++;
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, rsp_if.status);
                    end
                end
                if (recv_quiet > 0) begin
                    recv_quiet--;
                    recv_hold = 0;
                end else begin
                    recv_hold = pick_gap();
                    if ($urandom_range(0, 99) < 3) recv_quiet = $urandom_range(20, 80);
                end
                // one long hold-off so the block backs up into the sender
                if (n_results == PRESSURE_AT) recv_hold = PRESSURE_CYCLES;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
                     WATCHDOG_LIMIT, answers_due.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int                         span;
        int                         r;
        bit                         fill;
        bit                         fill_next;
        logic [btmx_pkg::KEY_W-1:0] k;

        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.opcode = btmx_pkg::OP_CLEAR;
        req_if.key    = '0;
        rsp_if.ready  = 1'b0;
        foreach (shadow_links[n]) begin
            shadow_links[n][0] = '0;
            shadow_links[n][1] = '0;
        end
        shadow_last = 0;
        shadow_keys = '0;

        // directed: extremes, every opcode, empty and duplicate cases, reuse after clear
        push_beat(btmx_pkg::OP_QUERY,  31'h0000_0000);
        push_beat(btmx_pkg::OP_NONE,   31'h7fff_ffff);
        push_beat(btmx_pkg::OP_INSERT, 31'h0000_0000);
        push_beat(btmx_pkg::OP_QUERY,  31'h7fff_ffff);
        push_beat(btmx_pkg::OP_INSERT, 31'h7fff_ffff);
        push_beat(btmx_pkg::OP_QUERY,  31'h4000_0000);
        push_beat(btmx_pkg::OP_QUERY,  31'h3fff_ffff);
        push_beat(btmx_pkg::OP_INSERT, 31'h0000_0000);
        push_beat(btmx_pkg::OP_QUERY,  31'h5555_5555);
        push_beat(btmx_pkg::OP_QUERY,  31'h2aaa_aaaa);
        push_beat(btmx_pkg::OP_NONE,   31'h2aaa_aaaa);
        push_beat(btmx_pkg::OP_CLEAR,  31'h7fff_ffff);
        push_beat(btmx_pkg::OP_QUERY,  31'h0000_0000);
        push_beat(btmx_pkg::OP_INSERT, 31'h5555_5555);
        push_beat(btmx_pkg::OP_QUERY,  31'h5555_5554);
        push_beat(btmx_pkg::OP_QUERY,  31'h2aaa_aaaa);
        push_beat(btmx_pkg::OP_INSERT, 31'h0000_0001);
        push_beat(btmx_pkg::OP_QUERY,  31'h0000_0000);
        push_beat(btmx_pkg::OP_CLEAR,  31'h0000_0000);
        push_beat(btmx_pkg::OP_NONE,   31'h0000_0000);
        push_beat(btmx_pkg::OP_INSERT, 31'h7fff_fffe);
        push_beat(btmx_pkg::OP_QUERY,  31'h7fff_ffff);

        // random episodes, each opened by a clear; fill episodes run the trie out of nodes
        fill_next = 1'b1;
        while (beats_to_send.size() < ITEM_COUNT) begin
            fill      = fill_next || ($urandom_range(0, 99) < 25);
            fill_next = 1'b0;
            span      = fill ? $urandom_range(350, 500) : $urandom_range(10, 120);
            push_beat(btmx_pkg::OP_CLEAR, fresh_key());
            key_pool.delete();
            for (int n = 0; n < span && beats_to_send.size() < ITEM_COUNT; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    push_beat(btmx_pkg::OP_NONE, fresh_key());
                end else if (r < 6 && !fill) begin
                    push_beat(btmx_pkg::OP_CLEAR, fresh_key());
                    key_pool.delete();
                end else if (r < (fill ? 80 : 52)) begin
                    k = pick_key(fill ? 70 : 30);
                    push_beat(btmx_pkg::OP_INSERT, k);
                    key_pool.insert(key_pool.size(), k);
                end else begin
                    push_beat(btmx_pkg::OP_QUERY, pick_key(fill ? 40 : 20));
                end
            end
        end

        total_beats = beats_to_send.size();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < total_beats || answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d results: %0d answered queries, %0d empty-trie queries,",
                 n_sent, n_results, n_answered, n_empty);
        $display("%0d full rejects, highest node used %0d of %0d, key count peaked at %0d",
                 n_full, peak_node, btmx_pkg::NODE_COUNT - 1, peak_keys);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/btmx_pkg.sv
rtl/btmx_if.sv
rtl/btmx_ctrl.sv
rtl/btmx_datapath.sv
rtl/binary_trie_min_xor_top.sv
tb/binary_trie_min_xor_top_tb.sv
